### src/ppeg_pkg.sv
// shared types, constants and helper functions of the pixel effect generator
// no dependencies; used by the channel interfaces and the top level

package ppeg_pkg;

  localparam int unsigned CoordW = 6;
  localparam int unsigned ColorW = 4;
  localparam int unsigned TimeW  = 16;
  localparam int unsigned SelW   = 7;

  localparam logic [TimeW-1:0] FRAME_TIME_RESET = 16'd19;

  // effect selection codes, frame_time / 512
  localparam logic [SelW-1:0] EFF_TUNNEL = 7'd0;
  localparam logic [SelW-1:0] EFF_RINGS  = 7'd1;
  localparam logic [SelW-1:0] EFF_CHECK  = 7'd5;

  // tunnel setup: 4*(x-10) and 4*(y-10)-24, both mod 256
  localparam logic [7:0] TUN_X_OFS    = 8'd216;
  localparam logic [7:0] TUN_Y_OFS    = 8'd192;
  localparam logic [7:0] DEPTH_START  = 8'hF7;
  localparam logic [7:0] TUN_BIAS     = 8'd4;

  // ring centre
  localparam logic [7:0] RING_X_CTR = 8'd20;
  localparam logic [7:0] RING_Y_CTR = 8'd24;

  localparam logic [7:0] CHK_OR  = 8'hDB;
  localparam logic [7:0] CHK_ADD = 8'h13;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TUN_Y,
    ST_TUN_X,
    ST_RING_Y,
    ST_RING_X,
    ST_FIN
  } ppeg_state_t;

  function automatic logic [ColorW-1:0] checker_color(
    input logic [CoordW-1:0] x,
    input logic [CoordW-1:0] y,
    input logic [TimeW-1:0]  ft
  );
    logic [15:0] v;
    logic [7:0]  c;
    v = {2'b00, y, 2'b00, x} - ft;
    c = (v[15:8] ^ v[7:0]) | CHK_OR;
    c = c + CHK_ADD;
    return c[ColorW-1:0];
  endfunction

endpackage

### src/ppeg_if.sv
// valid/ready channel interfaces: pixel requests, colour results, time writes
// depends on ppeg_pkg for field widths

interface ppeg_pix_in_if
  import ppeg_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] pixel_x;
  logic [CoordW-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface ppeg_pix_out_if
  import ppeg_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [ColorW-1:0] pixel_color;

  modport source (output valid, output pixel_color, input ready);
  modport sink   (input valid, input pixel_color, output ready);
endinterface

interface ppeg_cfg_if
  import ppeg_pkg::*;
  ;
  logic             valid;
  logic             ready;
  logic [TimeW-1:0] frame_time;

  modport source (output valid, output frame_time, input ready);
  modport sink   (input valid, input frame_time, output ready);
endinterface

### src/procedural_pixel_effect_generator_unit.sv
// procedural pixel effect generator: one pixel coordinate in, one 4-bit colour out.
// The effect is chosen by frame_time[15:9]: 0 is a bent raycast tunnel, 1 is
// squared-distance rings, 5 is an xor checkerboard, every other code gives 0.
// A single signed 8x8 multiplier is shared by the tunnel and ring effects under a
// small sequencer, and one request is worked on at a time. Each tunnel depth step
// needs two products, and a tunnel pixel takes 1 to 247 depth steps; a ring
// pixel needs two products and the other effects none. The result sits in an
// output register, so the next request can start while the previous colour
// still waits. frame_time resets to 19 and is written through the cfg channel,
// which is always ready.
// depends on ppeg_pkg and the channel interfaces in ppeg_if

module procedural_pixel_effect_generator_unit
  import ppeg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  ppeg_pix_in_if.sink           in_pix,
  ppeg_pix_out_if.source        out_pix,
  ppeg_cfg_if.sink              cfg_time
);

  ppeg_state_t       state_r, state_nxt;
  logic [TimeW-1:0]  frame_time_r, frame_time_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ColorW-1:0] out_color_r, out_color_nxt;

  // operand registers: tunnel xc/ya, or ring dx/dy
  logic [7:0]        opx_r, opx_nxt;
  logic [7:0]        opy_r, opy_nxt;
  logic [7:0]        depth_r, depth_nxt;
  logic [7:0]        hy_r, hy_nxt;
  logic [ColorW-1:0] acc_r, acc_nxt;
  logic [ColorW-1:0] col_r, col_nxt;

  logic              in_accept;
  logic              load_out;
  logic [SelW-1:0]   sel;
  logic signed [7:0] mul_a, mul_b;
  logic signed [15:0] prod;
  logic [7:0]        tun_a;
  logic [7:0]        depth_dec;
  logic [7:0]        tun_c;
  logic [7:0]        depth_time;
  logic              tun_stop;

  assign sel       = frame_time_r[TimeW-1 -: SelW];
  assign in_accept = in_pix.valid && in_pix.ready;
  assign load_out  = (state_r == ST_FIN) && (!out_valid_r || out_pix.ready);

  assign in_pix.ready        = (state_r == ST_IDLE);
  assign out_pix.valid       = out_valid_r;
  assign out_pix.pixel_color = out_color_r;
  assign cfg_time.ready      = 1'b1;

  // shared multiplier, operands picked by the sequencer
  always_comb begin
    case (state_r)
      ST_TUN_Y: begin
        mul_a = opy_r;
        mul_b = depth_r;
      end
      ST_TUN_X: begin
        mul_a = tun_a;
        mul_b = depth_r;
      end
      ST_RING_Y: begin
        mul_a = opy_r;
        mul_b = opy_r;
      end
      ST_RING_X: begin
        mul_a = opx_r;
        mul_b = opx_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = 16'(mul_a) * 16'(mul_b);

  assign tun_a      = opx_r + depth_r;
  assign depth_dec  = depth_r - 8'd1;
  assign tun_c      = (hy_r ^ prod[15:8]) + TUN_BIAS;
  assign depth_time = depth_dec - frame_time_r[7:0];
  // stop on zero depth or when the projection hits a wall
  assign tun_stop   = (depth_dec == 8'd0) || (tun_c[7:3] != 5'd0);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          case (sel)
            EFF_TUNNEL: state_nxt = ST_TUN_Y;
            EFF_RINGS:  state_nxt = ST_RING_Y;
            default:    state_nxt = ST_FIN;
          endcase
        end
      end
      ST_TUN_Y:  state_nxt = ST_TUN_X;
      ST_TUN_X:  state_nxt = tun_stop ? ST_FIN : ST_TUN_Y;
      ST_RING_Y: state_nxt = ST_RING_X;
      ST_RING_X: state_nxt = ST_FIN;
      ST_FIN: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    opx_nxt        = opx_r;
    opy_nxt        = opy_r;
    depth_nxt      = depth_r;
    hy_nxt         = hy_r;
    acc_nxt        = acc_r;
    col_nxt        = col_r;
    frame_time_nxt = frame_time_r;
    out_color_nxt  = out_color_r;
    out_valid_nxt  = out_valid_r;

    if (cfg_time.valid && cfg_time.ready) begin
      frame_time_nxt = cfg_time.frame_time;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          depth_nxt = DEPTH_START;
          col_nxt   = '0;
          if (sel == EFF_RINGS) begin
            opx_nxt = 8'({2'b00, in_pix.pixel_x}) - RING_X_CTR;
            opy_nxt = 8'({2'b00, in_pix.pixel_y}) - RING_Y_CTR;
          end else begin
            opx_nxt = {in_pix.pixel_x, 2'b00} + TUN_X_OFS;
            opy_nxt = {in_pix.pixel_y, 2'b00} + TUN_Y_OFS;
          end
          if (sel == EFF_CHECK) begin
            col_nxt = checker_color(in_pix.pixel_x, in_pix.pixel_y, frame_time_r);
          end
        end
      end
      ST_TUN_Y: begin
        hy_nxt = prod[15:8];
      end
      ST_TUN_X: begin
        depth_nxt = depth_dec;
        if (depth_dec == 8'd0) begin
          col_nxt = {1'b0, tun_a[2:0] ^ depth_time[2:0]};
        end else begin
          col_nxt = {1'b0, tun_c[2:0] ^ depth_time[2:0]};
        end
      end
      ST_RING_Y: begin
        // squares are non-negative, /32 is a shift
        acc_nxt = prod[8:5];
      end
      ST_RING_X: begin
        col_nxt = acc_r + prod[8:5] + frame_time_r[3:0];
      end
      default: begin
      end
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_color_nxt = col_r;
    end else if (out_pix.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      frame_time_r <= FRAME_TIME_RESET;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      frame_time_r <= frame_time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    opx_r       <= opx_nxt;
    opy_r       <= opy_nxt;
    depth_r     <= depth_nxt;
    hy_r        <= hy_nxt;
    acc_r       <= acc_nxt;
    col_r       <= col_nxt;
    out_color_r <= out_color_nxt;
  end

endmodule

### tb/sv/tb_procedural_pixel_effect_generator_unit.sv
`timescale 1ns / 100ps
// testbench for procedural_pixel_effect_generator_unit: random and directed pixel requests
// checked against a colour predictor; depends on ppeg_pkg and the channel interfaces in ppeg_if

typedef struct {
  logic [5:0]  x;
  logic [5:0]  y;
  logic [15:0] frame_time;
  logic [3:0]  color;
} pixel_expect_t;

class pixel_color_board;
  localparam int KIND_TUNNEL = 0;
  localparam int KIND_RINGS  = 1;
  localparam int KIND_TILES  = 2;
  localparam int KIND_BLANK  = 3;

  pixel_expect_t expected_colors[$];
  logic [15:0]   frame_time;
  int unsigned   errors;
  int unsigned   matched;
  int unsigned   kind_count[4];

  function new();
    frame_time = ppeg_pkg::FRAME_TIME_RESET;
    errors     = 0;
    matched    = 0;
    foreach (kind_count[i]) kind_count[i] = 0;
  endfunction

  function void set_frame_time(logic [15:0] value);
    frame_time = value;
  endfunction

  function int unsigned pending();
    return expected_colors.size();
  endfunction

  // depth march along a bent ray until a wall byte shows up or depth runs out
  function logic [3:0] tunnel_color(logic [5:0] x, logic [5:0] y);
    logic [7:0]         xc, ya, depth, a, c, shade;
    logic signed [15:0] py, px;
    bit                 hit;
    xc    = {x, 2'b00} + 8'd216;
    ya    = {y, 2'b00} + 8'd192;
    depth = 8'hF7;
    hit   = 1'b0;
    c     = 8'd0;
    while (!hit) begin
      a     = xc + depth;
      py    = 16'($signed(ya)) * 16'($signed(depth));
      px    = 16'($signed(a)) * 16'($signed(depth));
      depth = depth - 8'd1;
      if (depth == 8'd0) begin
        c   = a;
        hit = 1'b1;
      end else begin
        c = (py[15:8] ^ px[15:8]) + 8'd4;
        if ((c & 8'hF8) != 8'd0) hit = 1'b1;
      end
    end
    shade = depth - frame_time[7:0];
    c     = c ^ shade;
    return {1'b0, c[2:0]};
  endfunction

  function logic [3:0] ring_color(logic [5:0] x, logic [5:0] y);
    int          dy, dx;
    logic [31:0] sum;
    dy  = int'(y) - 24;
    dx  = int'(x) - 20;
    sum = 32'((dy * dy) / 32 + (dx * dx) / 32) + 32'(frame_time);
    return sum[3:0];
  endfunction

  function logic [3:0] tile_color(logic [5:0] x, logic [5:0] y);
    logic [15:0] v;
    logic [7:0]  c;
    v = {2'b00, y, 2'b00, x} - frame_time;
    c = (v[15:8] ^ v[7:0]) | 8'hDB;
    c = c + 8'h13;
    return c[3:0];
  endfunction

  function void note_pixel(logic [5:0] x, logic [5:0] y);
    pixel_expect_t e;
    e.x          = x;
    e.y          = y;
    e.frame_time = frame_time;
    case (frame_time[15:9])
      ppeg_pkg::EFF_TUNNEL: begin
        e.color = tunnel_color(x, y);
        kind_count[KIND_TUNNEL]++;
      end
      ppeg_pkg::EFF_RINGS: begin
        e.color = ring_color(x, y);
        kind_count[KIND_RINGS]++;
      end
      ppeg_pkg::EFF_CHECK: begin
        e.color = tile_color(x, y);
        kind_count[KIND_TILES]++;
      end
      default: begin
        e.color = 4'd0;
        kind_count[KIND_BLANK]++;
      end
    endcase
    expected_colors.push_back(e);
  endfunction

  function void check_color(logic [3:0] got);
    pixel_expect_t e;
    if (expected_colors.size() == 0) begin
      errors++;
      $display("%0t: colour %0d arrived with no request outstanding", $time, got);
      return;
    end
    e = expected_colors.pop_front();
    if (got !== e.color) begin
      errors++;
      $display("%0t: pixel (%0d,%0d) time %04h: expected colour %0d, got %0d",
               $time, e.x, e.y, e.frame_time, e.color, got);
    end else begin
      matched++;
    end
  endfunction

  function void report_kinds();
    $display("tunnel %0d, rings %0d, checkerboard %0d, blank %0d",
             kind_count[KIND_TUNNEL], kind_count[KIND_RINGS],
             kind_count[KIND_TILES], kind_count[KIND_BLANK]);
  endfunction
endclass

module tb_procedural_pixel_effect_generator_unit;
  import ppeg_pkg::*;

  localparam logic [SelW-1:0] EFF_STUB_2 = 7'd2;
  localparam logic [SelW-1:0] EFF_STUB_3 = 7'd3;
  localparam logic [SelW-1:0] EFF_STUB_4 = 7'd4;
  localparam logic [SelW-1:0] EFF_STUB_6 = 7'd6;
  localparam logic [SelW-1:0] EFF_QUIT   = 7'd7;
  localparam logic [SelW-1:0] SEL_MAX    = 7'h7F;

  localparam int RANDOM_PIXELS = 1330;
  localparam int HOLD_CYCLES   = 300;
  localparam int GAP_MAX       = 6;
  // every pixel at the longest tunnel march plus both gaps, taken several times over
  localparam longint CYCLE_LIMIT = 4_000_000;

  logic clk;
  logic rst_n;

  ppeg_pix_in_if  pix_in ();
  ppeg_pix_out_if pix_out ();
  ppeg_cfg_if     cfg_ch ();

  procedural_pixel_effect_generator_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (pix_in),
    .out_pix  (pix_out),
    .cfg_time (cfg_ch)
  );

  pixel_color_board board = new();

  longint      cycles = 0;
  int          src_gap_max;
  int          sink_gap_max;
  bit          hold_out_req;
  int unsigned time_writes;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side: random ready gaps, one long hold-off on request
  initial begin
    int unsigned sink_wait;
    sink_wait     = 0;
    pix_out.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (pix_out.valid && pix_out.ready) begin
        board.check_color(pix_out.pixel_color);
        sink_wait = $urandom_range(0, sink_gap_max);
      end
      if (hold_out_req) begin
        sink_wait    = HOLD_CYCLES;
        hold_out_req = 1'b0;
      end
      if (sink_wait > 0) begin
        pix_out.ready <= 1'b0;
        sink_wait--;
      end else begin
        pix_out.ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  // valid stays high into the next request when the gap is zero
  task automatic send_pixel(input logic [5:0] x, input logic [5:0] y);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      pix_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_in.valid   <= 1'b1;
    pix_in.pixel_x <= x;
    pix_in.pixel_y <= y;
    do @(posedge clk); while (!pix_in.ready);
    board.note_pixel(x, y);
  endtask

  task automatic drain();
    pix_in.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_frame_time(input logic [15:0] value);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.frame_time <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    board.set_frame_time(value);
    time_writes++;
  endtask

  task automatic send_random_pixel();
    // mostly the full 6-bit range, sometimes only the visible screen
    if ($urandom_range(0, 3) == 0)
      send_pixel(6'($urandom_range(0, 39)), 6'($urandom_range(0, 47)));
    else
      send_pixel(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
  endtask

  function automatic logic [15:0] pick_frame_time();
    logic [SelW-1:0] sel;
    case ($urandom_range(0, 9))
      0, 1, 2: sel = EFF_TUNNEL;
      3, 4:    sel = EFF_RINGS;
      5, 6:    sel = EFF_CHECK;
      7: begin
        case ($urandom_range(0, 3))
          0:       sel = EFF_STUB_2;
          1:       sel = EFF_STUB_3;
          2:       sel = EFF_STUB_4;
          default: sel = EFF_STUB_6;
        endcase
      end
      8:       sel = EFF_QUIT;
      default: sel = SEL_MAX - 7'($urandom_range(0, SEL_MAX - EFF_QUIT - 1));
    endcase
    return {sel, 9'($urandom_range(0, 511))};
  endfunction

  initial begin
    logic [SelW-1:0] blank_sels[7];
    logic [15:0]     ft;
    int              sent;
    int              phase;
    int              phase_len;

    blank_sels = '{EFF_STUB_2, EFF_STUB_3, EFF_STUB_4, EFF_STUB_6, EFF_QUIT,
                   EFF_QUIT + 7'd1, SEL_MAX};
    time_writes       = 0;
    hold_out_req      = 1'b0;
    src_gap_max       = GAP_MAX;
    sink_gap_max      = GAP_MAX;
    rst_n             <= 1'b0;
    pix_in.valid      <= 1'b0;
    pix_in.pixel_x    <= '0;
    pix_in.pixel_y    <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.frame_time <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // tunnel at the reset time, corners and the tunnel origin
    send_pixel(6'd0, 6'd0);
    send_pixel(6'd63, 6'd63);
    send_pixel(6'd0, 6'd63);
    send_pixel(6'd63, 6'd0);
    send_pixel(6'd10, 6'd10);
    send_pixel(6'd39, 6'd47);
    drain();

    write_frame_time({EFF_RINGS, 9'd0});
    send_pixel(6'd20, 6'd24);
    send_pixel(6'd0, 6'd0);
    send_pixel(6'd63, 6'd63);
    send_pixel(6'd39, 6'd47);
    drain();

    write_frame_time({EFF_CHECK, 9'h1FF});
    send_pixel(6'd0, 6'd0);
    send_pixel(6'd63, 6'd63);
    send_pixel(6'd5, 6'd40);
    drain();

    // stub effects, quit code and codes past it all give black
    foreach (blank_sels[i]) begin
      write_frame_time({blank_sels[i], 9'($urandom_range(0, 511))});
      send_random_pixel();
      drain();
    end

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_PIXELS) begin
      case (phase)
        0:       ft = 16'h0000;
        1:       ft = 16'hFFFF;
        2:       ft = 16'h01FF;
        4:       ft = {EFF_RINGS, 9'($urandom_range(0, 511))};
        default: ft = pick_frame_time();
      endcase
      write_frame_time(ft);
      src_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
      sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
      if (phase == 4) begin
        // back-to-back requests against a stalled output
        src_gap_max  = 0;
        hold_out_req = 1'b1;
      end
      phase_len = $urandom_range(30, 70);
      for (int i = 0; i < phase_len && sent < RANDOM_PIXELS; i++) begin
        send_random_pixel();
        sent++;
      end
      drain();
      phase++;
    end

    repeat (10) @(posedge clk);
    if (board.pending() != 0) board.errors++;
    $display("%0d colours matched over %0d frame time settings", board.matched, time_writes);
    board.report_kinds();
    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
